// ===== rtl/afg_pkg.sv =====
// afg_pkg: shared types, constants and codes of the playback fifo with gain
// no dependencies; used by afg_if, afg_lane, the top level and the testbench
`timescale 1ns / 1ps

package afg_pkg;

   localparam int DEPTH_FRAMES  = 1024;
   localparam int ADDR_BITS     = $clog2(DEPTH_FRAMES);
   localparam int FREE_BITS     = ADDR_BITS + 1;
   localparam int COUNT_BITS    = 32;
   localparam int SAMPLE_BITS   = 16;
   localparam int FRAME_BITS    = 2 * SAMPLE_BITS;
   localparam int GAIN_BITS     = 16;
   localparam int GAIN_FRAC     = 14;
   localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int CHAN_BITS     = 2;
   localparam int KIND_BITS     = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(16384);
   localparam logic [CHAN_BITS-1:0] CHAN_RESET = CHAN_BITS'(2);
   localparam logic [CHAN_BITS-1:0] CHAN_MONO  = CHAN_BITS'(1);

   // request kinds; the remaining code is a no-op
   typedef enum logic [KIND_BITS-1:0] {
      KIND_WRITE = 2'd0,
      KIND_PLAY  = 2'd1,
      KIND_FLUSH = 2'd2
   } kind_type;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_GAIN    = 1'b0,
      REG_CHANNEL = 1'b1
   } reg_index_type;

   // per-request status travelling alongside the lanes
   typedef struct packed {
      logic                  accepted;
      logic                  underrun;
      logic [FREE_BITS-1:0]  free_slots;
      logic [COUNT_BITS-1:0] played_frames;
      logic                  block_end;
      logic                  deliver;
   } status_type;

   // lane stage controls
   typedef struct packed {
      logic load_mul;
      logic load_out;
      logic keep;
   } lane_ctrl_type;

endpackage

// ===== rtl/afg_if.sv =====
// afg request and response channel interfaces (valid/ready with payload)
// depends on afg_pkg
`timescale 1ns / 1ps

interface afg_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [afg_pkg::KIND_BITS-1:0]         kind;
   logic signed [afg_pkg::SAMPLE_BITS-1:0] sample_left;
   logic signed [afg_pkg::SAMPLE_BITS-1:0] sample_right;
   logic                                  end_of_block;

   modport source (output valid, kind, sample_left, sample_right, end_of_block, input ready);
   modport sink (input valid, kind, sample_left, sample_right, end_of_block, output ready);
endinterface

interface afg_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [afg_pkg::SAMPLE_BITS-1:0] out_left;
   logic signed [afg_pkg::SAMPLE_BITS-1:0] out_right;
   logic                                   accepted;
   logic                                   underrun;
   logic [afg_pkg::FREE_BITS-1:0]          free_slots;
   logic [afg_pkg::COUNT_BITS-1:0]         played_frames;
   logic                                   block_end;

   modport source (output valid, out_left, out_right, accepted, underrun, free_slots,
                   played_frames, block_end, input ready);
   modport sink (input valid, out_left, out_right, accepted, underrun, free_slots,
                 played_frames, block_end, output ready);
endinterface

// ===== rtl/afg_ram.sv =====
// afg_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module afg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/afg_lane.sv =====
// afg_lane: one gain lane, registered multiply then round and saturate
// depends on afg_pkg
`timescale 1ns / 1ps

module afg_lane (
   input  logic                                   clock,
   input  afg_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [afg_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [afg_pkg::GAIN_BITS-1:0]          gain,
   output logic signed [afg_pkg::SAMPLE_BITS-1:0] result
);

   localparam int PB = afg_pkg::PROD_BITS;
   localparam int SB = afg_pkg::SAMPLE_BITS;
   localparam logic signed [PB-1:0] ROUND_HALF = PB'(1) <<< (afg_pkg::GAIN_FRAC - 1);
   localparam logic signed [PB-1:0] SAT_MAX    = (PB'(1) <<< (SB - 1)) - PB'(1);
   localparam logic signed [PB-1:0] SAT_MIN    = -(PB'(1) <<< (SB - 1));

   logic signed [PB-1:0] prod_ff, prod_in;
   logic                 keep_ff;
   logic signed [SB-1:0] result_ff, result_in;
   logic signed [afg_pkg::GAIN_BITS:0] gain_s;
   logic signed [PB-1:0] rounded, shifted;

   always_comb begin
      gain_s  = {1'b0, gain};
      prod_in = PB'(sample) * PB'(gain_s);
   end

   // round to nearest, ties upward, then clamp to the sample range; a frame not kept gives zero
   always_comb begin
      rounded = prod_ff + ROUND_HALF;
      shifted = rounded >>> afg_pkg::GAIN_FRAC;
      if (!keep_ff) begin
         result_in = '0;
      end else if (shifted > SAT_MAX) begin
         result_in = SB'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         result_in = SB'(SAT_MIN);
      end else begin
         result_in = SB'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod_ff <= prod_in;
         keep_ff <= ctrl.keep;
      end
      if (ctrl.load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== rtl/audio_playback_fifo_with_gain.sv =====
// audio_playback_fifo_with_gain: top level, ring control, csr block, stage control and merge
// depends on afg_pkg, afg_if, afg_ram and afg_lane
`timescale 1ns / 1ps

// channel   role      handshake      carries
// req       sink      valid/ready    kind, sample_left, sample_right, end_of_block
// rsp       source    valid/ready    out_left, out_right, accepted, underrun, free_slots,
//                                    played_frames, block_end
// csr_*     apb slave psel/penable   gain (0x0), channel_count (0x4)
//
// one request per cycle sustained while responses are taken; a response appears after its
// request passes the ring ram read, lane multiply and lane round/saturate, each registered
// each stage moves on when it is empty or the next stage moves, so a waiting response
// does not block the input while earlier stages still have room
// reset (synchronous) empties the ring and the pipeline and restores gain and channel
// count; the ring ram needs no clearing as only written slots are ever read

module audio_playback_fifo_with_gain (
   input  logic                                clock,
   input  logic                                reset,
   afg_req_if.sink                             req,
   afg_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [afg_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [afg_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [afg_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int CB = afg_pkg::COUNT_BITS;
   localparam int FB = afg_pkg::FREE_BITS;
   localparam int AB = afg_pkg::ADDR_BITS;
   localparam int SB = afg_pkg::SAMPLE_BITS;

   // configuration registers
   logic [afg_pkg::GAIN_BITS-1:0] gain_ff;
   logic [afg_pkg::CHAN_BITS-1:0] chan_ff;
   logic                          csr_write;
   afg_pkg::reg_index_type        csr_index;

   // ring counters
   logic [CB-1:0] wr_count_ff, wr_count_in;
   logic [CB-1:0] rd_count_ff, rd_count_in;
   logic [CB-1:0] used_now, used_after;

   // pipeline
   logic                  v1_ff, v2_ff, v3_ff;
   afg_pkg::status_type   s1_ff, s2_ff, s3_ff, s1_in;
   logic                  en1, en2, en3, accept;
   logic                  do_write, do_play;
   logic [afg_pkg::FRAME_BITS-1:0] rd_frame;
   afg_pkg::lane_ctrl_type ctrl_left, ctrl_right;
   logic signed [SB-1:0]  lane_left, lane_right;

   // ---------------- csr port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = afg_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      case (csr_index)
         afg_pkg::REG_GAIN:    csr_prdata = afg_pkg::CSR_DATA_BITS'(gain_ff);
         afg_pkg::REG_CHANNEL: csr_prdata = afg_pkg::CSR_DATA_BITS'(chan_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= afg_pkg::GAIN_RESET;
         chan_ff <= afg_pkg::CHAN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            afg_pkg::REG_GAIN:    gain_ff <= csr_pwdata[afg_pkg::GAIN_BITS-1:0];
            afg_pkg::REG_CHANNEL: chan_ff <= csr_pwdata[afg_pkg::CHAN_BITS-1:0];
            default:              gain_ff <= gain_ff;
         endcase
      end
   end

   // ---------------- stage handshake ----------------
   assign en3       = !v3_ff || rsp.ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req.ready = en1;
   assign accept    = req.valid && en1;

   // ---------------- ring decisions at request time ----------------
   always_comb begin
      used_now    = wr_count_ff - rd_count_ff;
      wr_count_in = wr_count_ff;
      rd_count_in = rd_count_ff;
      do_write    = 1'b0;
      do_play     = 1'b0;
      s1_in       = '0;
      case (req.kind)
         afg_pkg::KIND_WRITE: begin
            // full ring drops the frame
            if (used_now != CB'(afg_pkg::DEPTH_FRAMES)) begin
               do_write    = 1'b1;
               wr_count_in = wr_count_ff + CB'(1);
            end
            s1_in.accepted = do_write;
         end
         afg_pkg::KIND_PLAY: begin
            if (used_now == '0) begin
               s1_in.underrun = 1'b1;
            end else begin
               do_play     = 1'b1;
               rd_count_in = rd_count_ff + CB'(1);
            end
            s1_in.accepted = do_play;
            s1_in.deliver  = do_play;
         end
         afg_pkg::KIND_FLUSH: begin
            // flushed frames count as played
            rd_count_in = wr_count_ff;
         end
         default: begin
            // unused kind: no change
            rd_count_in = rd_count_ff;
         end
      endcase
      used_after          = wr_count_in - rd_count_in;
      s1_in.free_slots    = FB'(afg_pkg::DEPTH_FRAMES) - used_after[FB-1:0];
      s1_in.played_frames = rd_count_in;
      s1_in.block_end     = req.end_of_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_count_ff <= '0;
         rd_count_ff <= '0;
      end else if (accept) begin
         wr_count_ff <= wr_count_in;
         rd_count_ff <= rd_count_in;
      end
   end

   // ---------------- frame ring ----------------
   afg_ram #(
      .WIDTH (afg_pkg::FRAME_BITS),
      .DEPTH (afg_pkg::DEPTH_FRAMES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && do_write),
      .wr_addr (wr_count_ff[AB-1:0]),
      .wr_data ({req.sample_right, req.sample_left}),
      .rd_en   (accept && do_play),
      .rd_addr (rd_count_ff[AB-1:0]),
      .rd_data (rd_frame)
   );

   // ---------------- status pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= accept;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (en2) begin
         s2_ff <= s1_ff;
      end
      if (en3) begin
         s3_ff <= s2_ff;
      end
   end

   // ---------------- gain lanes ----------------
   // the right lane is silenced in mono; any other channel count plays stereo
   always_comb begin
      ctrl_left.load_mul  = en2;
      ctrl_left.load_out  = en3;
      ctrl_left.keep      = v1_ff && s1_ff.deliver;
      ctrl_right.load_mul = en2;
      ctrl_right.load_out = en3;
      ctrl_right.keep     = v1_ff && s1_ff.deliver && (chan_ff != afg_pkg::CHAN_MONO);
   end

   afg_lane u_lane_left (
      .clock  (clock),
      .ctrl   (ctrl_left),
      .sample (rd_frame[SB-1:0]),
      .gain   (gain_ff),
      .result (lane_left)
   );

   afg_lane u_lane_right (
      .clock  (clock),
      .ctrl   (ctrl_right),
      .sample (rd_frame[2*SB-1:SB]),
      .gain   (gain_ff),
      .result (lane_right)
   );

   // ---------------- merge into the response ----------------
   assign rsp.valid         = v3_ff;
   assign rsp.out_left      = lane_left;
   assign rsp.out_right     = lane_right;
   assign rsp.accepted      = s3_ff.accepted;
   assign rsp.underrun      = s3_ff.underrun;
   assign rsp.free_slots    = s3_ff.free_slots;
   assign rsp.played_frames = s3_ff.played_frames;
   assign rsp.block_end     = s3_ff.block_end;

   // ---------------- checks ----------------
   a_occupancy_bound : assert property (@(posedge clock) disable iff (reset)
      (wr_count_ff - rd_count_ff) <= CB'(afg_pkg::DEPTH_FRAMES))
      else $error("ring occupancy beyond depth");

   a_accept_fills_stage1 : assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("request taken but first stage empty");

   a_underrun_silent : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.underrun |-> rsp.out_left == '0 && rsp.out_right == '0
                                    && !rsp.accepted)
      else $error("underrun response carries samples");

   a_counters_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> rd_count_ff == $past(rd_count_ff) && wr_count_ff == $past(wr_count_ff))
      else $error("ring counters moved without a request");

endmodule

// ===== tb/sv/tb_audio_playback_fifo_with_gain.sv =====
`timescale 1ns / 1ps
// tb_audio_playback_fifo_with_gain: self-checking testbench for the playback fifo with gain
// depends on afg_pkg, afg_if and the rtl top level audio_playback_fifo_with_gain

module tb_audio_playback_fifo_with_gain;
   import afg_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 5;
   localparam int IDLE_PCT     = 29;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 6;      // three-stage pipe plus margin
   localparam int PHASE_ITEMS  = 20;
   localparam int FILL_ITEMS   = DEPTH_FRAMES + 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   // the spare kind code, a no-op in the block
   localparam logic [KIND_BITS-1:0] KIND_NOP = 2'd3;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = '0;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ONES = '1;

   typedef struct packed {
      logic [KIND_BITS-1:0]          kind;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          end_of_block;
   } frame_request_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic                          accepted;
      logic                          underrun;
      logic [FREE_BITS-1:0]          free_slots;
      logic [COUNT_BITS-1:0]         played_frames;
      logic                          block_end;
   } frame_result_type;

   // ring model, gain path and queue of responses still owed by the block
   class playback_scoreboard;
      logic [SAMPLE_BITS-1:0] ring_left[DEPTH_FRAMES];
      logic [SAMPLE_BITS-1:0] ring_right[DEPTH_FRAMES];
      logic [COUNT_BITS-1:0]  write_total = '0;
      logic [COUNT_BITS-1:0]  read_total  = '0;
      logic [GAIN_BITS-1:0]   gain        = GAIN_RESET;
      logic [CHAN_BITS-1:0]   channels    = CHAN_RESET;
      frame_result_type       due_frames[$];
      int failures = 0, requests = 0, responses = 0, delivered = 0;
      int dropped = 0, underruns = 0, flushes = 0, saturations = 0, settings = 0;

      function void set_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         settings++;
         if (idx == REG_GAIN) begin
            gain = value[GAIN_BITS-1:0];
         end else begin
            channels = value[CHAN_BITS-1:0];
         end
      endfunction

      // q2.14 gain, round half up, clip to the sample range
      function logic signed [SAMPLE_BITS-1:0] gained_sample(logic signed [SAMPLE_BITS-1:0] s);
         longint p;
         p = (longint'(s) * longint'(gain) + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
         if (p > longint'(SAMPLE_MAX)) begin
            p = longint'(SAMPLE_MAX);
            saturations++;
         end else if (p < longint'(SAMPLE_MIN)) begin
            p = longint'(SAMPLE_MIN);
            saturations++;
         end
         return p[SAMPLE_BITS-1:0];
      endfunction

      function void note_request(frame_request_type rq);
         frame_result_type       r;
         logic [COUNT_BITS-1:0]  used;
         int                     slot;
         r = '0;
         r.block_end = rq.end_of_block;
         used = write_total - read_total;
         requests++;
         case (rq.kind)
            KIND_WRITE: begin
               if (used < DEPTH_FRAMES) begin
                  slot = int'(write_total[ADDR_BITS-1:0]);
                  ring_left[slot]  = rq.left;
                  ring_right[slot] = rq.right;
                  write_total++;
                  r.accepted = 1'b1;
               end else begin
                  dropped++;
               end
            end
            KIND_PLAY: begin
               if (used == 0) begin
                  r.underrun = 1'b1;
                  underruns++;
               end else begin
                  slot = int'(read_total[ADDR_BITS-1:0]);
                  r.out_left = gained_sample(ring_left[slot]);
                  if (channels != CHAN_MONO) begin
                     r.out_right = gained_sample(ring_right[slot]);
                  end
                  read_total++;
                  r.accepted = 1'b1;
                  delivered++;
               end
            end
            KIND_FLUSH: begin
               read_total = write_total;
               flushes++;
            end
            default: begin
            end
         endcase
         used = write_total - read_total;
         r.free_slots    = (used >= DEPTH_FRAMES) ? '0 : FREE_BITS'(DEPTH_FRAMES - used);
         r.played_frames = read_total;
         due_frames.push_back(r);
      endfunction

      function void check_response(frame_result_type got);
         frame_result_type want;
         string            diff;
         responses++;
         if (due_frames.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("response %0d arrived with nothing outstanding", responses);
            end
            return;
         end
         want = due_frames.pop_front();
         diff = "";
         if (got.out_left !== want.out_left)           diff = {diff, " out_left"};
         if (got.out_right !== want.out_right)         diff = {diff, " out_right"};
         if (got.accepted !== want.accepted)           diff = {diff, " accepted"};
         if (got.underrun !== want.underrun)           diff = {diff, " underrun"};
         if (got.free_slots !== want.free_slots)       diff = {diff, " free_slots"};
         if (got.played_frames !== want.played_frames) diff = {diff, " played_frames"};
         if (got.block_end !== want.block_end)         diff = {diff, " block_end"};
         if (diff != "") begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("response %0d differs in%s", responses, diff);
               $display("  expected l=%0d r=%0d acc=%0b und=%0b free=%0d played=%0d end=%0b",
                        want.out_left, want.out_right, want.accepted, want.underrun,
                        want.free_slots, want.played_frames, want.block_end);
               $display("  actual   l=%0d r=%0d acc=%0b und=%0b free=%0d played=%0d end=%0b",
                        got.out_left, got.out_right, got.accepted, got.underrun,
                        got.free_slots, got.played_frames, got.block_end);
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   afg_req_if req_chan ();
   afg_rsp_if rsp_chan ();

   playback_scoreboard playback = new();

   // steady: neither side idles; hold_pending asks the receiver for a long hold-off
   bit steady       = 1'b0;
   bit hold_pending = 1'b0;
   int hold_left    = 0;
   int cycles       = 0;

   audio_playback_fifo_with_gain u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // run guard; the figure is far above the slowest legal run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: ready changes at the falling edge, long hold-off counted here
   always begin
      @(negedge clock);
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // responses are taken at the rising edge, before the block updates its outputs
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         playback.check_response(frame_result_type'{rsp_chan.out_left, rsp_chan.out_right,
                                                    rsp_chan.accepted, rsp_chan.underrun,
                                                    rsp_chan.free_slots, rsp_chan.played_frames,
                                                    rsp_chan.block_end});
      end
   end

   function automatic frame_request_type request_of(logic [KIND_BITS-1:0] kind,
                                                    logic signed [SAMPLE_BITS-1:0] left,
                                                    logic signed [SAMPLE_BITS-1:0] right,
                                                    logic eob);
      frame_request_type rq;
      rq.kind = kind;
      rq.left = left;
      rq.right = right;
      rq.end_of_block = eob;
      return rq;
   endfunction

   // extremes turn up often enough to hit the clipping path
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_ONES;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // write_pct and play_pct split the mix; the rest is mostly flush, a little no-op
   function automatic frame_request_type random_request(int write_pct, int play_pct);
      int pick;
      logic [KIND_BITS-1:0] kind;
      pick = $urandom_range(0, 99);
      if (pick < write_pct) begin
         kind = KIND_WRITE;
      end else if (pick < write_pct + play_pct) begin
         kind = KIND_PLAY;
      end else if (pick < 98) begin
         kind = KIND_FLUSH;
      end else begin
         kind = KIND_NOP;
      end
      return request_of(kind, random_sample(), random_sample(), $urandom_range(0, 7) == 0);
   endfunction

   // offer one request from the falling edge, note it once the block takes it
   task automatic send_request(input frame_request_type rq);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= rq.kind;
      req_chan.sample_left  <= rq.left;
      req_chan.sample_right <= rq.right;
      req_chan.end_of_block <= rq.end_of_block;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      playback.note_request(rq);
   endtask

   // stop offering and wait for every owed response, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (playback.due_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle; pready is sampled at the rising edge
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      playback.set_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input logic [GAIN_BITS-1:0] g, input logic [CHAN_BITS-1:0] ch);
      wait_drained();
      csr_write(REG_GAIN, CSR_DATA_BITS'(g));
      csr_write(REG_CHANNEL, CSR_DATA_BITS'(ch));
   endtask

   logic [GAIN_BITS-1:0] phase_gain[6];
   logic [CHAN_BITS-1:0] phase_chan[6];

   initial begin
      // every input known from time zero
      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_chan.valid        = 1'b0;
      req_chan.kind         = KIND_WRITE;
      req_chan.sample_left  = '0;
      req_chan.sample_right = '0;
      req_chan.end_of_block = 1'b0;
      rsp_chan.ready        = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings (unity gain, stereo)
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b1));   // underrun on empty
      send_request(request_of(KIND_WRITE, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
      send_request(request_of(KIND_WRITE, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
      send_request(request_of(KIND_WRITE, SAMPLE_ZERO, SAMPLE_ONES, 1'b0));
      send_request(request_of(KIND_WRITE, 16'sh0001, 16'sh5555, 1'b0));
      send_request(request_of(KIND_WRITE, SAMPLE_ONES, 16'shAAAA, 1'b1));
      send_request(request_of(KIND_NOP, SAMPLE_MAX, SAMPLE_MAX, 1'b1));      // spare kind
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b0));
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b1));
      send_request(request_of(KIND_FLUSH, SAMPLE_ZERO, SAMPLE_ZERO, 1'b0));  // three left behind
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b0));

      // top gain in mono: both clip limits, right lane forced to zero
      apply_setting('1, CHAN_MONO);
      send_request(request_of(KIND_WRITE, SAMPLE_MAX, SAMPLE_MAX, 1'b0));
      send_request(request_of(KIND_WRITE, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
      send_request(request_of(KIND_WRITE, 16'sh2000, -16'sh2000, 1'b0));
      send_request(request_of(KIND_WRITE, 16'sh0001, SAMPLE_ONES, 1'b1));
      repeat (4) send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b0));

      // zero gain with channel code 3, then smallest gain with code 0 (both stereo)
      apply_setting('0, 2'd3);
      send_request(request_of(KIND_WRITE, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b1));
      apply_setting(16'd1, 2'd0);
      send_request(request_of(KIND_WRITE, SAMPLE_ONES, 16'sh0001, 1'b0));
      send_request(request_of(KIND_WRITE, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
      send_request(request_of(KIND_PLAY, SAMPLE_ZERO, SAMPLE_ZERO, 1'b0));
      send_request(request_of(KIND_FLUSH, SAMPLE_ZERO, SAMPLE_ZERO, 1'b1));

      // random phases over a spread of settings
      phase_gain = '{GAIN_RESET, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000, GAIN_BITS'($urandom)};
      phase_chan = '{CHAN_RESET, CHAN_RESET, CHAN_MONO, 2'd3, 2'd0,
                     CHAN_BITS'($urandom_range(1, 2))};
      for (int p = 0; p < 6; p++) begin
         apply_setting(phase_gain[p], phase_chan[p]);
         steady = (p == 1);              // a stretch with no idling either side
         if (p == 2) hold_pending = 1'b1; // receiver stalls, sender keeps offering
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == PHASE_ITEMS / 2) begin
               wait_drained();           // sender pauses until the pipe is empty
            end
            send_request(random_request(50, 45));
         end
         steady = 1'b0;
      end

      // fill the ring past full so writes get dropped, back to back with no idling,
      // then send a mix that is mostly plays
      apply_setting(GAIN_BITS'($urandom), CHAN_RESET);
      steady = 1'b1;
      for (int i = 0; i < FILL_ITEMS; i++) begin
         send_request(random_request(100, 0));
      end
      steady = 1'b0;
      for (int i = 0; i < 40; i++) begin
         send_request(random_request(20, 75));
      end

      wait_drained();

      $display("ran %0d requests, checked %0d responses over %0d register writes",
               playback.requests, playback.responses, playback.settings);
      $display("%0d frames played, %0d dropped on full, %0d underruns, %0d flushes, %0d clipped",
               playback.delivered, playback.dropped, playback.underruns, playback.flushes,
               playback.saturations);
      if (playback.failures == 0 && playback.due_frames.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== audio_playback_fifo_with_gain.f =====
rtl/afg_pkg.sv
rtl/afg_if.sv
rtl/afg_ram.sv
rtl/afg_lane.sv
rtl/audio_playback_fifo_with_gain.sv
tb/sv/tb_audio_playback_fifo_with_gain.sv
